[src/skyra_pkg.sv]
package skyra_pkg;

  localparam int MAX_SEGMENTS_DEF = 64;
  localparam int COORD_W = 13;
  localparam int POS_W = 12;
  localparam int STATUS_W = 2;

  localparam logic [COORD_W-1:0] ATLAS_WIDTH_RST = 13'd512;
  localparam logic [COORD_W-1:0] ATLAS_HEIGHT_RST = 13'd512;

  // Configuration register indexes.
  localparam logic CFG_ATLAS_WIDTH = 1'b0;
  localparam logic CFG_ATLAS_HEIGHT = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_ROOM = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] w;
  } seg_t;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_CLEAR,
    OP_ACCEPT,
    OP_RD_A,
    OP_FIT_A,
    OP_FIT_CHK,
    OP_FIT_B,
    OP_DECIDE,
    OP_INS,
    OP_INS_WR,
    OP_TRIM_CHK,
    OP_TRIM_EV,
    OP_RM,
    OP_RM_WR,
    OP_MRG_CHK,
    OP_MRG_A,
    OP_MRG_B,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic a_end;
    logic anc_fail;
    logic anc_zero;
    logic left_done;
    logic cur_end;
    logic b_fail;
    logic best_v;
    logic full;
    logic ins_more;
    logic i_end;
    logic trim_stop;
    logic trim_rm;
    logic rm_more;
    logic mrg_more;
    logic mrg_eq;
  } sts_t;

endpackage

[src/skyra_if.sv]
interface skyra_req_if;
  logic valid;
  logic ready;
  logic action;
  logic [12:0] req_width;
  logic [12:0] req_height;

  modport source (output valid, output action, output req_width, output req_height,
                  input ready);
  modport sink (input valid, input action, input req_width, input req_height,
                output ready);
endinterface

interface skyra_res_if;
  logic valid;
  logic ready;
  logic [11:0] pos_x;
  logic [11:0] pos_y;
  logic [1:0] status;

  modport source (output valid, output pos_x, output pos_y, output status, input ready);
  modport sink (input valid, input pos_x, input pos_y, input status, output ready);
endinterface

[src/skyra_dp.sv]
module skyra_dp #(
  parameter int MAX_SEGS = skyra_pkg::MAX_SEGMENTS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  skyra_pkg::cmd_t cmd,
  output skyra_pkg::sts_t sts,
  input  logic [skyra_pkg::COORD_W-1:0] atlas_width,
  input  logic [skyra_pkg::COORD_W-1:0] atlas_height,
  input  logic [skyra_pkg::COORD_W-1:0] in_width,
  input  logic [skyra_pkg::COORD_W-1:0] in_height,
  output logic [skyra_pkg::POS_W-1:0] pos_x,
  output logic [skyra_pkg::POS_W-1:0] pos_y,
  output logic [skyra_pkg::STATUS_W-1:0] status
);
  import skyra_pkg::*;

  localparam int AW = $clog2(MAX_SEGS);
  localparam int CW = $clog2(MAX_SEGS + 1);

  seg_t mem [MAX_SEGS];
  seg_t rdata;
  seg_t wdata;
  seg_t hold;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic we;

  logic [COORD_W-1:0] rw;
  logic [COORD_W-1:0] rh;
  logic [CW-1:0] count;
  logic [CW-1:0] a;
  logic [CW-1:0] cur;
  logic [CW-1:0] i;
  logic [CW-1:0] k;
  logic [CW-1:0] best;
  logic best_v;
  logic [COORD_W-1:0] fy;
  logic [COORD_W-1:0] ax;
  logic [COORD_W-1:0] anw;
  logic [COORD_W-1:0] best_x;
  logic [COORD_W-1:0] best_y;
  logic [COORD_W-1:0] best_w;
  logic signed [COORD_W+1:0] left;
  logic [COORD_W-1:0] res_x;
  logic [COORD_W-1:0] res_y;
  logic [STATUS_W-1:0] res_st;

  logic [COORD_W-1:0] clr_w;
  logic [COORD_W+1:0] anc_right;
  logic [COORD_W+1:0] anc_bottom;
  logic [COORD_W-1:0] ny;
  logic [COORD_W+1:0] ny_bottom;
  logic [COORD_W:0] trim_end;
  logic [COORD_W:0] seg_end;
  logic [CW-1:0] k_m1;
  logic [CW:0] k_p1;
  logic [CW:0] i_p1;
  logic cand_zero;
  logic cand_chk;

  assign clr_w = (atlas_width >= 13'd2) ? atlas_width - 13'd2 : '0;
  assign anc_right = {2'b00, rdata.x} + {2'b00, rw} + 15'd1;
  assign anc_bottom = {2'b00, rdata.y} + {2'b00, rh} + 15'd1;
  assign ny = (rdata.y > fy) ? rdata.y : fy;
  assign ny_bottom = {2'b00, ny} + {2'b00, rh} + 15'd1;
  assign trim_end = {1'b0, best_x} + {1'b0, rw};
  assign seg_end = {1'b0, rdata.x} + {1'b0, rdata.w};
  assign k_m1 = k - CW'(1);
  assign k_p1 = {1'b0, k} + (CW+1)'(1);
  assign i_p1 = {1'b0, i} + (CW+1)'(1);

  always_comb begin
    sts.a_end = a >= count;
    sts.anc_fail = (anc_right > {2'b00, atlas_width}) ||
                   (anc_bottom > {2'b00, atlas_height});
    sts.anc_zero = rw == '0;
    sts.left_done = left[COORD_W+1] || (left == '0);
    sts.cur_end = cur >= count;
    sts.b_fail = ny_bottom > {2'b00, atlas_height};
    sts.best_v = best_v;
    sts.full = count >= CW'(MAX_SEGS);
    sts.ins_more = k > best;
    sts.i_end = i >= count;
    sts.trim_stop = {1'b0, rdata.x} >= trim_end;
    sts.trim_rm = seg_end <= trim_end;
    sts.rm_more = k_p1 < {1'b0, count};
    sts.mrg_more = i_p1 < {1'b0, count};
    sts.mrg_eq = hold.y == rdata.y;
  end

  // A candidate replaces the best fit when it sits lower, or equally low on a narrower segment.
  assign cand_zero = !best_v || (rdata.y < best_y) || ((rdata.y == best_y) && (rdata.w < best_w));
  assign cand_chk = !best_v || (fy < best_y) || ((fy == best_y) && (anw < best_w));

  always_comb begin
    raddr = '0;
    waddr = '0;
    wdata = '0;
    we = 1'b0;
    case (cmd.op)
      OP_CLEAR: begin
        we = 1'b1;
        wdata = '{x: 13'd1, y: 13'd1, w: clr_w};
      end
      OP_RD_A: raddr = a[AW-1:0];
      OP_FIT_CHK: raddr = cur[AW-1:0];
      OP_INS: begin
        if (sts.ins_more) begin
          raddr = k_m1[AW-1:0];
        end else begin
          we = 1'b1;
          waddr = best[AW-1:0];
          wdata = '{x: best_x, y: best_y + rh, w: rw};
        end
      end
      OP_INS_WR: begin
        we = 1'b1;
        waddr = k[AW-1:0];
        wdata = rdata;
      end
      OP_TRIM_CHK: raddr = i[AW-1:0];
      OP_TRIM_EV: begin
        if (!sts.trim_stop && !sts.trim_rm) begin
          we = 1'b1;
          waddr = i[AW-1:0];
          wdata = '{x: trim_end[COORD_W-1:0], y: rdata.y,
                    w: COORD_W'(seg_end - trim_end)};
        end
      end
      OP_RM: raddr = k_p1[AW-1:0];
      OP_RM_WR: begin
        we = 1'b1;
        waddr = k[AW-1:0];
        wdata = rdata;
      end
      OP_MRG_CHK: raddr = i[AW-1:0];
      OP_MRG_A: raddr = i_p1[AW-1:0];
      OP_MRG_B: begin
        if (sts.mrg_eq) begin
          we = 1'b1;
          waddr = i[AW-1:0];
          wdata = '{x: hold.x, y: hold.y, w: hold.w + rdata.w};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= CW'(1);
      best_v <= 1'b0;
    end else begin
      case (cmd.op)
        OP_CLEAR: begin
          count <= CW'(1);
          res_x <= '0;
          res_y <= '0;
          res_st <= ST_OK;
        end
        OP_ACCEPT: begin
          rw <= in_width;
          rh <= in_height;
          best_v <= 1'b0;
          a <= '0;
        end
        OP_FIT_A: begin
          if (sts.anc_fail) begin
            a <= a + CW'(1);
          end else if (sts.anc_zero) begin
            if (cand_zero) begin
              best_v <= 1'b1;
              best <= a;
              best_x <= rdata.x;
              best_y <= rdata.y;
              best_w <= rdata.w;
            end
            a <= a + CW'(1);
          end else begin
            fy <= rdata.y;
            ax <= rdata.x;
            anw <= rdata.w;
            left <= $signed({2'b00, rw}) - $signed({2'b00, rdata.w});
            cur <= a + CW'(1);
          end
        end
        OP_FIT_CHK: begin
          if (sts.left_done) begin
            if (cand_chk) begin
              best_v <= 1'b1;
              best <= a;
              best_x <= ax;
              best_y <= fy;
              best_w <= anw;
            end
            a <= a + CW'(1);
          end else if (sts.cur_end) begin
            a <= a + CW'(1);
          end
        end
        OP_FIT_B: begin
          if (sts.b_fail) begin
            a <= a + CW'(1);
          end else begin
            fy <= ny;
            left <= left - $signed({2'b00, rdata.w});
            cur <= cur + CW'(1);
          end
        end
        OP_DECIDE: begin
          k <= count;
          if (!best_v) begin
            res_x <= '0;
            res_y <= '0;
            res_st <= ST_NO_ROOM;
          end else if (sts.full) begin
            res_x <= '0;
            res_y <= '0;
            res_st <= ST_FULL;
          end else begin
            res_x <= best_x;
            res_y <= best_y;
            res_st <= ST_OK;
          end
        end
        OP_INS: begin
          if (!sts.ins_more) begin
            count <= count + CW'(1);
            i <= best + CW'(1);
          end
        end
        OP_INS_WR: k <= k_m1;
        OP_TRIM_CHK: begin
          if (sts.i_end) begin
            i <= '0;
          end
        end
        OP_TRIM_EV: begin
          if (!sts.trim_stop && sts.trim_rm) begin
            k <= i;
          end else begin
            i <= '0;
          end
        end
        OP_RM: begin
          if (!sts.rm_more) begin
            count <= count - CW'(1);
          end
        end
        OP_RM_WR: k <= k_p1[CW-1:0];
        OP_MRG_A: hold <= rdata;
        OP_MRG_B: begin
          if (sts.mrg_eq) begin
            hold.w <= hold.w + rdata.w;
            k <= i_p1[CW-1:0];
          end else begin
            i <= i_p1[CW-1:0];
          end
        end
        OP_EMIT: begin
          pos_x <= res_x[POS_W-1:0];
          pos_y <= res_y[POS_W-1:0];
          status <= res_st;
        end
        default: ;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (count != '0) && (count <= CW'(MAX_SEGS)))
    else $error("segment count out of range");

  a_write_in_table: assert property (@(posedge clk) disable iff (rst)
    we |-> ({1'b0, waddr} <= (AW+1)'(count)))
    else $error("table write beyond the filled entries");

  a_insert_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_INS && !sts.ins_more) |-> !sts.full)
    else $error("insert into a full table");
`endif

endmodule

[src/skyra_ctrl.sv]
module skyra_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_action,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  skyra_pkg::sts_t sts,
  output skyra_pkg::cmd_t cmd
);
  import skyra_pkg::*;

  typedef enum logic [17:0] {
    S_INIT     = 18'h00001,
    S_IDLE     = 18'h00002,
    S_CLEAR    = 18'h00004,
    S_RD_A     = 18'h00008,
    S_FIT_A    = 18'h00010,
    S_FIT_CHK  = 18'h00020,
    S_FIT_B    = 18'h00040,
    S_DECIDE   = 18'h00080,
    S_INS      = 18'h00100,
    S_INS_WR   = 18'h00200,
    S_TRIM_CHK = 18'h00400,
    S_TRIM_EV  = 18'h00800,
    S_RM       = 18'h01000,
    S_RM_WR    = 18'h02000,
    S_MRG_CHK  = 18'h04000,
    S_MRG_A    = 18'h08000,
    S_MRG_B    = 18'h10000,
    S_DONE     = 18'h20000
  } state_t;

  state_t state;
  state_t state_next;
  logic rm_ret_mrg;
  logic rm_ret_mrg_next;
  logic out_free;
  logic accept;

  assign in_ready = state == S_IDLE;
  assign accept = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    rm_ret_mrg_next = rm_ret_mrg;
    cmd.op = OP_NOP;
    case (state)
      S_INIT: begin
        cmd.op = OP_CLEAR;
        state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          cmd.op = OP_ACCEPT;
          state_next = in_action ? S_RD_A : S_CLEAR;
        end
      end
      S_CLEAR: begin
        cmd.op = OP_CLEAR;
        state_next = S_DONE;
      end
      S_RD_A: begin
        cmd.op = OP_RD_A;
        state_next = sts.a_end ? S_DECIDE : S_FIT_A;
      end
      S_FIT_A: begin
        cmd.op = OP_FIT_A;
        state_next = (sts.anc_fail || sts.anc_zero) ? S_RD_A : S_FIT_CHK;
      end
      S_FIT_CHK: begin
        cmd.op = OP_FIT_CHK;
        state_next = (sts.left_done || sts.cur_end) ? S_RD_A : S_FIT_B;
      end
      S_FIT_B: begin
        cmd.op = OP_FIT_B;
        state_next = sts.b_fail ? S_RD_A : S_FIT_CHK;
      end
      S_DECIDE: begin
        cmd.op = OP_DECIDE;
        state_next = (!sts.best_v || sts.full) ? S_DONE : S_INS;
      end
      S_INS: begin
        cmd.op = OP_INS;
        state_next = sts.ins_more ? S_INS_WR : S_TRIM_CHK;
      end
      S_INS_WR: begin
        cmd.op = OP_INS_WR;
        state_next = S_INS;
      end
      S_TRIM_CHK: begin
        cmd.op = OP_TRIM_CHK;
        state_next = sts.i_end ? S_MRG_CHK : S_TRIM_EV;
      end
      S_TRIM_EV: begin
        cmd.op = OP_TRIM_EV;
        if (!sts.trim_stop && sts.trim_rm) begin
          rm_ret_mrg_next = 1'b0;
          state_next = S_RM;
        end else begin
          state_next = S_MRG_CHK;
        end
      end
      S_RM: begin
        cmd.op = OP_RM;
        if (sts.rm_more) begin
          state_next = S_RM_WR;
        end else begin
          state_next = rm_ret_mrg ? S_MRG_CHK : S_TRIM_CHK;
        end
      end
      S_RM_WR: begin
        cmd.op = OP_RM_WR;
        state_next = S_RM;
      end
      S_MRG_CHK: begin
        cmd.op = OP_MRG_CHK;
        state_next = sts.mrg_more ? S_MRG_A : S_DONE;
      end
      S_MRG_A: begin
        cmd.op = OP_MRG_A;
        state_next = S_MRG_B;
      end
      S_MRG_B: begin
        cmd.op = OP_MRG_B;
        if (sts.mrg_eq) begin
          rm_ret_mrg_next = 1'b1;
          state_next = S_RM;
        end else begin
          state_next = S_MRG_CHK;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.op = OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      rm_ret_mrg <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      rm_ret_mrg <= rm_ret_mrg_next;
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_clear_path: assert property (@(posedge clk) disable iff (rst)
    (accept && !in_action) |=> (state == S_CLEAR))
    else $error("clear request did not take the clear path");

  a_done_waits: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && !out_free) |=> (state == S_DONE))
    else $error("result dropped while output register busy");

  a_emit_sets_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free) |=> out_valid)
    else $error("emitted result not presented");
`endif

endmodule

[src/skyline_rect_allocator_unit.sv]
// A clear request passes through the clear state and then the done state before its result is presented; an allocate
// request reads segments while fitting, summed over all anchors, then moves entries on insert or removal
// and compares neighbors of equal height while merging.
// Throughput: one request at a time; the next is taken once the result is in the output register.
// Reset: synchronous, active high; the init state then writes the padding segment, width and height go to 512.
//
// The skyline lives in a single-port-read, single-port-write memory with a registered read,
// so every segment visit first issues an address and then takes its data from the read register.
// The controller sequences the scan of all anchors, keeping the lowest fit
// (ties to the narrower segment, then the earlier one), then shifts the table up to insert
// the new segment, trims or removes segments it covers, and sweeps the table merging
// neighbors of equal height. The result waits in an output register so that the next
// request can be accepted while it is still pending.
module skyline_rect_allocator_unit #(
  parameter int MAX_SEGMENTS = skyra_pkg::MAX_SEGMENTS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [skyra_pkg::COORD_W-1:0] cfg_data,
  skyra_req_if.sink req,
  skyra_res_if.source res
);
  import skyra_pkg::*;

  logic [COORD_W-1:0] atlas_width;
  logic [COORD_W-1:0] atlas_height;
  cmd_t cmd;
  sts_t sts;

  // Configuration registers; to be written by the user only while no request is in flight; not enforced.
  always_ff @(posedge clk) begin
    if (rst) begin
      atlas_width <= ATLAS_WIDTH_RST;
      atlas_height <= ATLAS_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ATLAS_WIDTH: atlas_width <= cfg_data;
        CFG_ATLAS_HEIGHT: atlas_height <= cfg_data;
        default: ;
      endcase
    end
  end

  skyra_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_action (req.action),
    .in_ready  (req.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  skyra_dp #(
    .MAX_SEGS (MAX_SEGMENTS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .atlas_width  (atlas_width),
    .atlas_height (atlas_height),
    .in_width     (req.req_width),
    .in_height    (req.req_height),
    .pos_x        (res.pos_x),
    .pos_y        (res.pos_y),
    .status       (res.status)
  );

endmodule
